// ===== rtl/core/srpg_pkg.sv =====
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared types and constants of the stepper ramp pulse generator.
// ----------------------------------------------------------------------------
package srpg_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int CFG_W          = 32;
    localparam int IV_W           = 32;
    localparam int RAMP_W         = 31;
    localparam int REST_W         = 33;
    localparam int DIV_W          = 34;
    localparam int OP_W           = DIV_W + 1;
    localparam int DIV_CNT_W      = $clog2(DIV_W + 1);

    localparam logic [IV_W-1:0] FIRST_PULSE_RST  = 32'd30230;
    localparam logic [IV_W-1:0] CRUISE_PULSE_RST = 32'd5000;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_BRAKE = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MS_STOPPED = 2'd0,
        MS_ACCEL   = 2'd1,
        MS_CRUISE  = 2'd2,
        MS_DECEL   = 2'd3
    } motion_t;

    typedef enum logic [1:0] {
        CFG_LINEAR_MODE  = 2'd0,
        CFG_RAMP_STEPS   = 2'd1,
        CFG_FIRST_PULSE  = 2'd2,
        CFG_CRUISE_PULSE = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic capture_in;
        logic do_start;
        logic do_step;
        logic do_brake;
        logic do_stop;
        logic div_start;
        logic div_stretch;
        logic stretch_apply;
        logic snap_cruise;
        logic upd_interval;
        logic upd_carry;
        logic load_out;
    } dp_ctrl_t;

    typedef struct packed {
        cmd_t    cmd;
        logic    linear;
        logic    rem_zero;
        motion_t motion;
        logic    accel_more;
        logic    div_done;
    } dp_stat_t;

endpackage

// ===== rtl/core/srpg_div.sv =====
// ----------------------------------------------------------------------------
// srpg_div
// Bit-serial signed divider, truncating quotient, remainder takes the
// dividend's sign; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srpg_div
    import srpg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [OP_W-1:0] dividend,
    input  logic signed [OP_W-1:0] divisor,
    output logic                   done,
    output logic signed [OP_W-1:0] quotient,
    output logic signed [OP_W-1:0] remainder
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W:0]       rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     den_reg;
    logic                 qneg_reg;
    logic                 rneg_reg;

    logic [OP_W-1:0]  num_abs;
    logic [OP_W-1:0]  den_abs;
    logic [DIV_W:0]   shifted;
    logic [DIV_W+1:0] trial;
    logic [OP_W-1:0]  quo_u;
    logic [OP_W-1:0]  rem_u;

    assign num_abs = dividend[OP_W-1] ? (~dividend + OP_W'(1)) : dividend;
    assign den_abs = divisor[OP_W-1] ? (~divisor + OP_W'(1)) : divisor;
    assign shifted = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= num_abs[DIV_W-1:0];
            den_reg  <= den_abs[DIV_W-1:0];
            qneg_reg <= dividend[OP_W-1] ^ divisor[OP_W-1];
            rneg_reg <= dividend[OP_W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_W+1])
            begin
                rem_reg <= trial[DIV_W:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign quo_u     = {1'b0, quo_reg};
    assign rem_u     = {1'b0, rem_reg[DIV_W-1:0]};
    assign quotient  = qneg_reg ? (~quo_u + OP_W'(1)) : quo_u;
    assign remainder = rneg_reg ? (~rem_u + OP_W'(1)) : rem_u;
    assign done      = done_reg;

endmodule

// ===== rtl/core/srpg_ctrl.sv =====
// ----------------------------------------------------------------------------
// srpg_ctrl
// Sequencer: takes one transaction, steps the datapath through the command
// and the divider passes, then hands the result to the output register.
// ----------------------------------------------------------------------------
module srpg_ctrl
    import srpg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    output logic     result_valid,
    input  logic     result_ready,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl
);

    typedef enum logic [8:0] {
        S_IDLE         = 9'b000000001,
        S_DECODE       = 9'b000000010,
        S_STRETCH_GO   = 9'b000000100,
        S_STRETCH_WAIT = 9'b000001000,
        S_CLASSIFY     = 9'b000010000,
        S_RAMP_Q_WAIT  = 9'b000100000,
        S_RAMP_R_GO    = 9'b001000000,
        S_RAMP_R_WAIT  = 9'b010000000,
        S_DONE         = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;
    logic   out_free;

    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg;
        ctrl              = '0;
        item_ready        = 1'b0;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    ctrl.capture_in = 1'b1;
                    state_next      = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.cmd)
                    CMD_START:
                    begin
                        ctrl.do_start = 1'b1;
                        state_next    = stat.linear ? S_DONE : S_STRETCH_GO;
                    end
                    CMD_STEP:
                    begin
                        if (stat.rem_zero)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ctrl.do_step = 1'b1;
                            state_next   = S_CLASSIFY;
                        end
                    end
                    CMD_BRAKE:
                    begin
                        ctrl.do_brake = 1'b1;
                        state_next    = S_DONE;
                    end
                    CMD_STOP:
                    begin
                        ctrl.do_stop = 1'b1;
                        state_next   = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_STRETCH_GO:
            begin
                if (stat.rem_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.div_start   = 1'b1;
                    ctrl.div_stretch = 1'b1;
                    state_next       = S_STRETCH_WAIT;
                end
            end
            S_STRETCH_WAIT:
            begin
                if (stat.div_done)
                begin
                    ctrl.stretch_apply = 1'b1;
                    state_next         = S_DONE;
                end
            end
            S_CLASSIFY:
            begin
                state_next = S_DONE;
                if (stat.linear)
                begin
                    if (stat.motion == MS_DECEL)
                    begin
                        ctrl.div_start = 1'b1;
                        state_next     = S_RAMP_Q_WAIT;
                    end
                    else if (stat.motion == MS_ACCEL)
                    begin
                        if (stat.accel_more)
                        begin
                            ctrl.div_start = 1'b1;
                            state_next     = S_RAMP_Q_WAIT;
                        end
                        else
                        begin
                            ctrl.snap_cruise = 1'b1;
                        end
                    end
                end
            end
            S_RAMP_Q_WAIT:
            begin
                if (stat.div_done)
                begin
                    ctrl.upd_interval = 1'b1;
                    state_next        = S_RAMP_R_GO;
                end
            end
            S_RAMP_R_GO:
            begin
                ctrl.div_start = 1'b1;
                state_next     = S_RAMP_R_WAIT;
            end
            S_RAMP_R_WAIT:
            begin
                if (stat.div_done)
                begin
                    ctrl.upd_carry = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ctrl.load_out     = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

endmodule

// ===== rtl/core/srpg_datapath.sv =====
// ----------------------------------------------------------------------------
// srpg_datapath
// Configuration and move state, ramp recurrence arithmetic, shared divider
// and the result register.
// ----------------------------------------------------------------------------
module srpg_datapath
    import srpg_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic [1:0]        command,
    input  logic [31:0]       move_steps,
    input  logic [31:0]       move_time_us,
    input  dp_ctrl_t          ctrl,
    output dp_stat_t          stat,
    output logic              step_issued,
    output logic [IV_W-1:0]   pulse_us,
    output logic              direction,
    output logic [1:0]        motion_state,
    output logic [31:0]       steps_left
);

    localparam int SW = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;
    localparam int RW = (COUNT_BITS > OP_W) ? COUNT_BITS : OP_W;
    localparam int LW = (COUNT_BITS > 32) ? COUNT_BITS : 32;
    localparam logic [SW-1:0] COUNT_MAX_W = {{(SW-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

    // configuration
    logic              linear_reg;
    logic [RAMP_W-1:0] ramp_reg;
    logic [IV_W-1:0]   first_reg;
    logic [IV_W-1:0]   cruise_cfg_reg;

    // captured transaction
    cmd_t        cmd_reg;
    logic [31:0] steps_reg;
    logic [31:0] time_reg;

    // move state
    logic [COUNT_BITS-1:0] remaining_reg;
    logic [COUNT_BITS-1:0] taken_reg;
    logic [COUNT_BITS-1:0] accel_end_reg;
    logic [COUNT_BITS-1:0] brake_start_reg;
    logic [IV_W-1:0]       interval_reg;
    logic [IV_W-1:0]       cruise_iv_reg;
    logic [REST_W-1:0]     carry_reg;
    logic                  dir_reg;

    // per-transaction result
    logic                  res_issued_reg;
    logic [IV_W-1:0]       res_pulse_reg;
    logic [COUNT_BITS-1:0] stop_left_reg;

    // result register
    logic              out_issued_reg;
    logic [IV_W-1:0]   out_pulse_reg;
    logic              out_dir_reg;
    logic [1:0]        out_motion_reg;
    logic [31:0]       out_left_reg;

    logic [31:0]           mag;
    logic [SW-1:0]         mag_w;
    logic [SW-1:0]         ramp_w;
    logic [COUNT_BITS-1:0] mag_sat;
    logic [COUNT_BITS-1:0] ramp_sat;
    logic [COUNT_BITS:0]   ramp_sum;
    logic                  short_move;
    logic [COUNT_BITS-1:0] half_move;

    motion_t motion;
    logic    rem_zero;

    logic [RW-1:0]          rem_r;
    logic [RW-1:0]          taken_r;
    logic [OP_W-1:0]        rem_op;
    logic [OP_W-1:0]        taken_op;
    logic signed [OP_W-1:0] ramp_num;
    logic signed [OP_W-1:0] ramp_den;
    logic signed [OP_W-1:0] div_num;
    logic signed [OP_W-1:0] div_den;
    logic                   div_done;
    logic signed [OP_W-1:0] div_quo;
    logic signed [OP_W-1:0] div_rem;

    logic signed [OP_W:0]  iv_diff;
    logic [IV_W-1:0]       iv_sat;
    logic [2:0]            rem_top;
    logic [REST_W-1:0]     carry_sat;
    logic [DIV_W-1:0]      q_mag;
    logic [DIV_W-1:0]      c_w;
    logic                  stretch;
    logic [COUNT_BITS-1:0] left_src;
    logic [LW-1:0]         left_w;

    // start decode
    assign mag        = steps_reg[31] ? (~steps_reg + 32'd1) : steps_reg;
    assign mag_w      = SW'(mag);
    assign ramp_w     = SW'(ramp_reg);
    assign mag_sat    = (mag_w > COUNT_MAX_W) ? {COUNT_BITS{1'b1}} : mag_w[COUNT_BITS-1:0];
    assign ramp_sat   = (ramp_w > COUNT_MAX_W) ? {COUNT_BITS{1'b1}} : ramp_w[COUNT_BITS-1:0];
    assign ramp_sum   = {1'b0, ramp_sat} + {1'b0, ramp_sat};
    assign short_move = {1'b0, mag_sat} < ramp_sum;
    assign half_move  = mag_sat >> 1;

    // motion classification
    assign rem_zero = (remaining_reg == '0);

    always_comb
    begin
        priority if (rem_zero)
        begin
            motion = MS_STOPPED;
        end
        else if (remaining_reg <= brake_start_reg)
        begin
            motion = MS_DECEL;
        end
        else if (taken_reg <= accel_end_reg)
        begin
            motion = MS_ACCEL;
        end
        else
        begin
            motion = MS_CRUISE;
        end
    end

    // divider operands
    assign rem_r    = RW'(remaining_reg);
    assign taken_r  = RW'(taken_reg);
    assign rem_op   = rem_r[OP_W-1:0];
    assign taken_op = taken_r[OP_W-1:0];
    assign ramp_num = $signed({2'b00, interval_reg, 1'b0})
                    + $signed({{(OP_W-REST_W){carry_reg[REST_W-1]}}, carry_reg});
    assign ramp_den = (motion == MS_DECEL)
                    ? $signed(OP_W'(1) - {rem_op[OP_W-3:0], 2'b00})
                    : $signed({taken_op[OP_W-3:0], 2'b00} + OP_W'(1));
    assign div_num  = ctrl.div_stretch ? $signed({{(OP_W-32){1'b0}}, time_reg}) : ramp_num;
    assign div_den  = ctrl.div_stretch ? $signed(rem_op) : ramp_den;

    srpg_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctrl.div_start),
        .dividend  (div_num),
        .divisor   (div_den),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // recurrence results
    assign iv_diff = $signed({{(OP_W+1-IV_W){1'b0}}, interval_reg})
                   - $signed({div_quo[OP_W-1], div_quo});

    always_comb
    begin
        priority if (iv_diff[OP_W])
        begin
            iv_sat = '0;
        end
        else if (|iv_diff[OP_W-1:IV_W])
        begin
            iv_sat = '1;
        end
        else
        begin
            iv_sat = iv_diff[IV_W-1:0];
        end
    end

    assign rem_top = div_rem[OP_W-1:REST_W-1];

    always_comb
    begin
        priority if ((&rem_top) || !(|rem_top))
        begin
            carry_sat = div_rem[REST_W-1:0];
        end
        else if (rem_top[2])
        begin
            carry_sat = {1'b1, {(REST_W-1){1'b0}}};
        end
        else
        begin
            carry_sat = {1'b0, {(REST_W-1){1'b1}}};
        end
    end

    // constant speed duration stretch
    assign q_mag   = div_quo[DIV_W-1:0];
    assign c_w     = DIV_W'(interval_reg);
    assign stretch = (q_mag > c_w) || ((q_mag == c_w) && (div_rem != '0));

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_reg     <= 1'b0;
            ramp_reg       <= '0;
            first_reg      <= FIRST_PULSE_RST;
            cruise_cfg_reg <= CRUISE_PULSE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LINEAR_MODE:  linear_reg     <= cfg_data[0];
                CFG_RAMP_STEPS:   ramp_reg       <= cfg_data[RAMP_W-1:0];
                CFG_FIRST_PULSE:  first_reg      <= cfg_data[IV_W-1:0];
                CFG_CRUISE_PULSE: cruise_cfg_reg <= cfg_data[IV_W-1:0];
                default:          linear_reg     <= linear_reg;
            endcase
        end
    end

    // transaction capture
    always_ff @(posedge clk)
    begin
        if (ctrl.capture_in)
        begin
            cmd_reg   <= cmd_t'(command);
            steps_reg <= move_steps;
            time_reg  <= move_time_us;
        end
    end

    // move state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg   <= '0;
            taken_reg       <= '0;
            accel_end_reg   <= '0;
            brake_start_reg <= '0;
            interval_reg    <= '0;
            cruise_iv_reg   <= '0;
            carry_reg       <= '0;
            dir_reg         <= 1'b0;
        end
        else
        begin
            if (ctrl.do_start)
            begin
                dir_reg       <= !steps_reg[31];
                remaining_reg <= mag_sat;
                taken_reg     <= '0;
                carry_reg     <= '0;
                cruise_iv_reg <= cruise_cfg_reg;
                if (linear_reg)
                begin
                    interval_reg <= first_reg;
                    if (short_move)
                    begin
                        accel_end_reg   <= half_move;
                        brake_start_reg <= mag_sat - half_move;
                    end
                    else
                    begin
                        accel_end_reg   <= ramp_sat;
                        brake_start_reg <= ramp_sat;
                    end
                end
                else
                begin
                    interval_reg    <= cruise_cfg_reg;
                    accel_end_reg   <= '0;
                    brake_start_reg <= '0;
                end
            end
            if (ctrl.do_step)
            begin
                remaining_reg <= remaining_reg - COUNT_BITS'(1);
                if (taken_reg != {COUNT_BITS{1'b1}})
                begin
                    taken_reg <= taken_reg + COUNT_BITS'(1);
                end
            end
            if (ctrl.do_brake)
            begin
                if (motion == MS_CRUISE)
                begin
                    remaining_reg <= brake_start_reg;
                end
                else if (motion == MS_ACCEL)
                begin
                    remaining_reg <= taken_reg;
                end
            end
            if (ctrl.do_stop)
            begin
                remaining_reg <= '0;
            end
            if (ctrl.stretch_apply && stretch)
            begin
                interval_reg <= div_quo[IV_W-1:0];
            end
            if (ctrl.snap_cruise)
            begin
                interval_reg <= cruise_iv_reg;
            end
            if (ctrl.upd_interval)
            begin
                interval_reg <= iv_sat;
            end
            if (ctrl.upd_carry)
            begin
                carry_reg <= carry_sat;
            end
        end
    end

    // per-transaction result
    always_ff @(posedge clk)
    begin
        if (ctrl.capture_in)
        begin
            res_issued_reg <= 1'b0;
            res_pulse_reg  <= '0;
        end
        if (ctrl.do_step)
        begin
            res_issued_reg <= 1'b1;
            res_pulse_reg  <= interval_reg;
        end
        if (ctrl.do_stop)
        begin
            stop_left_reg <= remaining_reg;
        end
    end

    assign left_src = (cmd_reg == CMD_STOP) ? stop_left_reg : remaining_reg;
    assign left_w   = LW'(left_src);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            out_issued_reg <= res_issued_reg;
            out_pulse_reg  <= res_pulse_reg;
            out_dir_reg    <= dir_reg;
            out_motion_reg <= 2'(motion);
            out_left_reg   <= left_w[31:0];
        end
    end

    assign stat.cmd        = cmd_reg;
    assign stat.linear     = linear_reg;
    assign stat.rem_zero   = rem_zero;
    assign stat.motion     = motion;
    assign stat.accel_more = taken_reg < accel_end_reg;
    assign stat.div_done   = div_done;

    assign step_issued  = out_issued_reg;
    assign pulse_us     = out_pulse_reg;
    assign direction    = out_dir_reg;
    assign motion_state = out_motion_reg;
    assign steps_left   = out_left_reg;

endmodule

// ===== rtl/core/stepper_ramp_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator
// Trapezoidal stepper pulse-interval generator, top level.
// ----------------------------------------------------------------------------
// usage
//   item channel (item_valid/item_ready) takes one command transaction:
//   start, step, brake or stop, with move_steps and move_time_us for start.
//   result channel (result_valid/result_ready) returns exactly one result
//   per transaction, in order.
//   cfg_we/cfg_index/cfg_data write one of the four setup registers, chosen by cfg_index;
//   write them only while no transaction is in flight.
// transaction flow
//   one transaction at a time. brake, stop, a step without a ramp update
//   and a linear start use no divider pass. a constant-speed start with a
//   nonzero count makes one pass of the bit-serial divider (34 quotient
//   bits) for the duration stretch; a ramp step makes two passes, for the
//   quotient and remainder of the ramp recurrence.
// reset
//   rst_n clears the move state and loads register defaults (first pulse
//   30230 us, cruise pulse 5000 us, constant mode, ramp length 0).
// stall
//   the result register holds a finished result while result_ready is low;
//   the next transaction is taken and worked on meanwhile, and waits only
//   at its own end until the register frees up.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_generator
    import srpg_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             item_valid,
    output logic             item_ready,
    input  logic [1:0]       command,
    input  logic [31:0]      move_steps,
    input  logic [31:0]      move_time_us,
    output logic             result_valid,
    input  logic             result_ready,
    output logic             step_issued,
    output logic [IV_W-1:0]  pulse_us,
    output logic             direction,
    output logic [1:0]       motion_state,
    output logic [31:0]      steps_left
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    srpg_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .ctrl         (ctrl)
    );

    srpg_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .command      (command),
        .move_steps   (move_steps),
        .move_time_us (move_time_us),
        .ctrl         (ctrl),
        .stat         (stat),
        .step_issued  (step_issued),
        .pulse_us     (pulse_us),
        .direction    (direction),
        .motion_state (motion_state),
        .steps_left   (steps_left)
    );

endmodule

// ===== bench/tb_stepper_ramp_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// tb_stepper_ramp_pulse_generator
// Drives command transactions into the stepper ramp pulse generator: first a
// short directed table, then random move sequences under changing register
// settings and handshake idling. A behavioral copy of the ramp arithmetic
// predicts results not in the table; each is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_stepper_ramp_pulse_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import srpg_pkg::*;

    localparam int NUM_ROWS       = 28;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 138;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [63:0] COUNT_MAX  = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] ACCEL_RATE = 64'd1000;
    localparam logic [63:0] DECEL_RATE = 64'd1000;
    localparam longint      IV_MAX     = 64'h0000_0000_FFFF_FFFF;
    localparam longint      REST_HI    = 64'h0000_0000_FFFF_FFFF;
    localparam longint      REST_LO    = 64'hFFFF_FFFF_0000_0000;

    typedef struct packed {
        logic        issued;
        logic [31:0] pulse;
        logic        dir;
        motion_t     state;
        logic [31:0] left;
    } pulse_res_t;

    typedef struct packed {
        logic        is_cfg;
        cfg_idx_t    reg_idx;
        logic [31:0] reg_val;
        cmd_t        cmd;
        logic [31:0] steps;
        logic [31:0] dur;
        logic        typed;
        pulse_res_t  want;
    } vec_row_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        cfg_we       = 1'b0;
    cfg_idx_t    cfg_index    = CFG_LINEAR_MODE;
    logic [31:0] cfg_data     = '0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    cmd_t        command      = CMD_START;
    logic [31:0] move_steps   = '0;
    logic [31:0] move_time_us = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic        step_issued;
    logic [31:0] pulse_us;
    logic        direction;
    logic [1:0]  motion_state;
    logic [31:0] steps_left;

    // register copies
    logic        mode_linear = 1'b0;
    logic [63:0] ramp_len    = '0;
    logic [63:0] first_iv    = 64'd30230;
    logic [63:0] cruise_reg  = 64'd5000;

    // move state
    logic [63:0] move_left  = '0;
    logic [63:0] steps_done = '0;
    logic [63:0] accel_len  = '0;
    logic [63:0] decel_from = '0;
    logic [63:0] cur_iv     = '0;
    logic [63:0] cruise_iv  = '0;
    longint      iv_rest    = 0;
    logic        move_dir   = 1'b0;

    pulse_res_t  pending_pulses [$];
    int          err_count     = 0;
    int          quiet_cycles  = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int unsigned burst_left    = 0;

    stepper_ramp_pulse_generator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .command      (command),
        .move_steps   (move_steps),
        .move_time_us (move_time_us),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .step_issued  (step_issued),
        .pulse_us     (pulse_us),
        .direction    (direction),
        .motion_state (motion_state),
        .steps_left   (steps_left)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] sat_count(logic [63:0] v);
        return (v > COUNT_MAX) ? COUNT_MAX : v;
    endfunction

    function automatic longint clamp_iv(longint v);
        if (v < 0)
            return 0;
        return (v > IV_MAX) ? IV_MAX : v;
    endfunction

    function automatic longint clamp_rest(longint v);
        if (v > REST_HI)
            return REST_HI;
        return (v < REST_LO) ? REST_LO : v;
    endfunction

    function automatic motion_t motion_now();
        if (move_left == 0)
            return MS_STOPPED;
        if (move_left <= decel_from)
            return MS_DECEL;
        if (steps_done <= accel_len)
            return MS_ACCEL;
        return MS_CRUISE;
    endfunction

    // c' = c - (2c + r) / d with remainder carry
    function automatic void ramp_update(longint d);
        longint c;
        c = clamp_iv($signed(cur_iv) - (2 * $signed(cur_iv) + iv_rest) / d);
        cur_iv = c;
        iv_rest = clamp_rest((2 * c + iv_rest) % d);
    endfunction

    function automatic void start_move(logic [31:0] steps, logic [31:0] dur);
        logic [63:0] mag;
        logic        stretch;
        mag = {32'd0, steps[31] ? -steps : steps};
        move_dir = ~steps[31];
        move_left = sat_count(mag);
        steps_done = 0;
        iv_rest = 0;
        if (mode_linear)
        begin
            accel_len = sat_count(ramp_len);
            decel_from = sat_count(accel_len * ACCEL_RATE / DECEL_RATE);
            if (move_left < accel_len + decel_from)
            begin
                // too short for a full ramp: split it
                accel_len = move_left * DECEL_RATE / (ACCEL_RATE + DECEL_RATE);
                decel_from = move_left - accel_len;
            end
            cur_iv = first_iv;
            cruise_iv = cruise_reg;
        end
        else
        begin
            accel_len = 0;
            decel_from = 0;
            cur_iv = cruise_reg;
            cruise_iv = cruise_reg;
            if (move_left == 0 || cur_iv == 0)
                stretch = (move_left != 0) && (dur != 0);
            else if (move_left > 64'hFFFF_FFFF)
                stretch = 1'b0;
            else
                stretch = dur > move_left * cur_iv;
            if (stretch)
                cur_iv = dur / move_left;
        end
    endfunction

    function automatic void advance_move();
        move_left--;
        if (steps_done < COUNT_MAX)
            steps_done++;
        if (!mode_linear)
            return;
        case (motion_now())
            MS_ACCEL:
            begin
                if (steps_done < accel_len)
                    ramp_update($signed(4 * steps_done + 1));
                else
                    cur_iv = cruise_iv;
            end
            MS_DECEL:
                ramp_update(1 - 4 * $signed(move_left));
            default:
                ;
        endcase
    endfunction

    function automatic pulse_res_t predict_pulse(cmd_t cmd, logic [31:0] steps,
                                                 logic [31:0] dur);
        pulse_res_t  r;
        logic [63:0] left;
        r = '0;
        case (cmd)
            CMD_START:
            begin
                start_move(steps, dur);
                left = move_left;
            end
            CMD_STEP:
            begin
                if (move_left != 0)
                begin
                    r.issued = 1'b1;
                    r.pulse = cur_iv[31:0];
                    advance_move();
                end
                left = move_left;
            end
            CMD_BRAKE:
            begin
                case (motion_now())
                    MS_CRUISE:
                        move_left = decel_from;
                    MS_ACCEL:
                        move_left = sat_count(steps_done * ACCEL_RATE / DECEL_RATE);
                    default:
                        ;
                endcase
                left = move_left;
            end
            default:
            begin
                left = move_left;
                move_left = 0;
            end
        endcase
        r.dir = move_dir;
        r.state = motion_now();
        r.left = left[31:0];
        return r;
    endfunction

    function automatic vec_row_t cfg_row(cfg_idx_t idx, logic [31:0] val);
        vec_row_t v;
        v = '0;
        v.is_cfg = 1'b1;
        v.reg_idx = idx;
        v.reg_val = val;
        return v;
    endfunction

    function automatic vec_row_t cmd_row(cmd_t cmd, logic [31:0] steps, logic [31:0] dur);
        vec_row_t v;
        v = '0;
        v.cmd = cmd;
        v.steps = steps;
        v.dur = dur;
        return v;
    endfunction

    function automatic vec_row_t chk_row(cmd_t cmd, logic [31:0] steps, logic [31:0] dur,
                                         logic issued, logic [31:0] pulse, logic dir,
                                         motion_t state, logic [31:0] left);
        vec_row_t v;
        v = cmd_row(cmd, steps, dur);
        v.typed = 1'b1;
        v.want = '{issued, pulse, dir, state, left};
        return v;
    endfunction

    function automatic void next_random_item(output cmd_t c, output logic [31:0] s,
                                             output logic [31:0] t);
        int unsigned roll;
        logic [31:0] mag;
        roll = $urandom_range(99);
        s = $urandom;
        t = $urandom;
        if (roll < 5)
            c = cmd_t'($urandom_range(3));
        else if (burst_left == 0 || roll < 7)
        begin
            c = CMD_START;
            case ($urandom_range(19))
                0:       mag = 32'd0;
                1, 2:    mag = $urandom;
                default: mag = $urandom_range(1, 120);
            endcase
            s = $urandom_range(1) ? -mag : mag;
            case ($urandom_range(2))
                0:       t = 32'd0;
                1:       t = $urandom_range(1, 1 << 20);
                default: ;
            endcase
            burst_left = (mag > 200) ? $urandom_range(20, 80) : mag + $urandom_range(0, 3);
        end
        else
        begin
            burst_left--;
            if (roll < 10)
                c = CMD_BRAKE;
            else if (roll < 12)
                c = CMD_STOP;
            else
                c = CMD_STEP;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
            err_count++;
        end
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_LINEAR_MODE:  mode_linear = val[0];
            CFG_RAMP_STEPS:   ramp_len = {33'd0, val[30:0]};
            CFG_FIRST_PULSE:  first_iv = {32'd0, val};
            CFG_CRUISE_PULSE: cruise_reg = {32'd0, val};
            default:          ;
        endcase
    endtask

    task automatic drain_pulses();
        item_valid <= 1'b0;
        while (pending_pulses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_item(cmd_t cmd, logic [31:0] steps, logic [31:0] dur,
                             logic typed, pulse_res_t want);
        pulse_res_t model_r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid   <= 1'b1;
        command      <= cmd;
        move_steps   <= steps;
        move_time_us <= dur;
        do
            @(posedge clk);
        while (item_ready !== 1'b1);
        model_r = predict_pulse(cmd, steps, dur);
        pending_pulses.push_back(typed ? want : model_r);
    endtask

    always @(posedge clk)
        result_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : result_check
        pulse_res_t want;
        if (result_valid === 1'b1 && result_ready)
        begin
            if (pending_pulses.size() == 0)
            begin
                $error("result transaction with no expectation pending");
                err_count++;
            end
            else
            begin
                want = pending_pulses.pop_front();
                check_field("step_issued", 32'(want.issued), 32'(step_issued));
                check_field("pulse_us", want.pulse, pulse_us);
                check_field("direction", 32'(want.dir), 32'(direction));
                check_field("motion_state", 32'(want.state), 32'(motion_state));
                check_field("steps_left", want.left, steps_left);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        vec_row_t    vec_tab [NUM_ROWS];
        cmd_t        c;
        logic [31:0] s;
        logic [31:0] t;
        logic [31:0] ramp_v;
        logic [31:0] first_v;
        logic [31:0] cruise_v;

        vec_tab = '{
            chk_row(CMD_STEP,  32'd0, 32'd0, 1'b0, 32'd0, 1'b0, MS_STOPPED, 32'd0),
            chk_row(CMD_BRAKE, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0, MS_STOPPED, 32'd0),
            chk_row(CMD_STOP,  32'd0, 32'd0, 1'b0, 32'd0, 1'b0, MS_STOPPED, 32'd0),
            chk_row(CMD_START, 32'd3, 32'd0, 1'b0, 32'd0, 1'b1, MS_ACCEL, 32'd3),
            chk_row(CMD_STEP,  32'd0, 32'd0, 1'b1, 32'd5000, 1'b1, MS_CRUISE, 32'd2),
            chk_row(CMD_BRAKE, 32'd0, 32'd0, 1'b0, 32'd0, 1'b1, MS_STOPPED, 32'd0),
            chk_row(CMD_START, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0, 1'b0, MS_ACCEL, 32'd1),
            chk_row(CMD_STEP,  32'd0, 32'd0, 1'b1, 32'd5000, 1'b0, MS_STOPPED, 32'd0),
            chk_row(CMD_START, 32'h8000_0000, 32'hFFFF_FFFF,
                    1'b0, 32'd0, 1'b0, MS_ACCEL, 32'h8000_0000),
            chk_row(CMD_STOP,  32'd0, 32'd0, 1'b0, 32'd0, 1'b0, MS_STOPPED, 32'h8000_0000),
            chk_row(CMD_START, 32'd0, 32'd12345, 1'b0, 32'd0, 1'b1, MS_STOPPED, 32'd0),
            chk_row(CMD_START, 32'd4, 32'd100000, 1'b0, 32'd0, 1'b1, MS_ACCEL, 32'd4),
            chk_row(CMD_STEP,  32'd0, 32'd0, 1'b1, 32'd25000, 1'b1, MS_CRUISE, 32'd3),
            chk_row(CMD_START, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                    1'b0, 32'd0, 1'b1, MS_ACCEL, 32'h7FFF_FFFF),
            cfg_row(CFG_LINEAR_MODE, 32'd1),
            cfg_row(CFG_RAMP_STEPS, 32'd4),
            cmd_row(CMD_START, 32'd20, 32'd0),
            cmd_row(CMD_STEP, 32'd0, 32'd0),
            cmd_row(CMD_STEP, 32'd0, 32'd0),
            cmd_row(CMD_STEP, 32'd0, 32'd0),
            cmd_row(CMD_STEP, 32'd0, 32'd0),
            cmd_row(CMD_STEP, 32'd0, 32'd0),
            cmd_row(CMD_BRAKE, 32'd0, 32'd0),
            cmd_row(CMD_STEP, 32'd0, 32'd0),
            cmd_row(CMD_BRAKE, 32'd0, 32'd0),
            cmd_row(CMD_START, 32'd5, 32'd0),
            cmd_row(CMD_STEP, 32'd0, 32'd0),
            cmd_row(CMD_BRAKE, 32'd0, 32'd0)
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vec_tab[i])
        begin
            if (vec_tab[i].is_cfg)
            begin
                drain_pulses();
                write_reg(vec_tab[i].reg_idx, vec_tab[i].reg_val);
            end
            else
                send_item(vec_tab[i].cmd, vec_tab[i].steps, vec_tab[i].dur,
                          vec_tab[i].typed, vec_tab[i].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_pulses();
            ramp_v   = (ph == 1) ? 32'h7FFF_FFFF : (ph == 4) ? 32'd0 :
                       (ph == 7) ? $urandom : $urandom_range(1, 40);
            first_v  = (ph == 1) ? 32'hFFFF_FFFF : (ph == 4) ? 32'd1 :
                       ($urandom_range(3) == 0) ? $urandom : $urandom_range(2000, 60000);
            cruise_v = (ph == 1 || ph == 2) ? 32'd1 :
                       (ph == 4 || ph == 5) ? 32'hFFFF_FFFF : $urandom_range(200, 8000);
            write_reg(CFG_LINEAR_MODE, {31'd0, ph % 3 != 2});
            write_reg(CFG_RAMP_STEPS, ramp_v);
            write_reg(CFG_FIRST_PULSE, first_v);
            write_reg(CFG_CRUISE_PULSE, cruise_v);
            // idle patterns: none, sender, receiver, both
            send_idle_pct = (ph % 4 == 1) ? 82 : (ph % 4 == 3) ? 27 : 0;
            stall_pct     = (ph % 4 == 2) ? 82 : (ph % 4 == 3) ? 27 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    drain_pulses();
                next_random_item(c, s, t);
                send_item(c, s, t, 1'b0, '0);
            end
        end

        drain_pulses();
        if (err_count == 0 && pending_pulses.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/srpg_pkg.sv
rtl/core/srpg_div.sv
rtl/core/srpg_ctrl.sv
rtl/core/srpg_datapath.sv
rtl/core/stepper_ramp_pulse_generator.sv
bench/tb_stepper_ramp_pulse_generator.sv
